/* rtl/pisf_pkg.sv */
// ----------------------------------------------------------------------------
// pisf_pkg: shared types and constants for the inverse-square force unit
// Fixed-point widths, configuration register codes and the word formats
// of the input and result channels.
// ----------------------------------------------------------------------------
package pisf_pkg;

    localparam int COORD_W  = 24;            // Q12.12 position
    localparam int MASS_W   = 24;            // unsigned Q12.12
    localparam int CHARGE_W = 24;            // signed Q12.12
    localparam int K_W      = 24;            // unsigned Q0.24 scale
    localparam int OFS_W    = COORD_W + 1;   // offset between two positions
    localparam int SQ_W     = 2 * OFS_W;     // one squared offset
    localparam int DSQ_W    = 50;            // Q26.24 squared distance
    localparam int PROD_W   = MASS_W + MASS_W;
    localparam int NUM_W    = PROD_W + K_W;  // Q24.48 numerator
    localparam int MAG_W    = 47;            // unsigned magnitude bits
    localparam int FORCE_W  = 48;            // signed Q24.24 force
    localparam int ROOT_W   = DSQ_W / 2;     // Q13.12 distance
    localparam int COS_W    = 25;            // Q1.24 direction cosine
    localparam int COS_FRAC = COS_W - 1;
    localparam int HALF_W   = 24;            // split point of wide products
    localparam int CFG_IDX_W = 2;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAV_K = 2'd0,
        CFG_ELEC_K = 2'd1
    } cfg_reg_e;

    localparam logic FUNC_GRAV = 1'b0;
    localparam logic FUNC_ELEC = 1'b1;

    typedef struct packed {
        logic                       func;
        logic signed [COORD_W-1:0]  a_pos_x;
        logic signed [COORD_W-1:0]  a_pos_y;
        logic signed [COORD_W-1:0]  a_pos_z;
        logic signed [COORD_W-1:0]  b_pos_x;
        logic signed [COORD_W-1:0]  b_pos_y;
        logic signed [COORD_W-1:0]  b_pos_z;
        logic        [MASS_W-1:0]   a_mass;
        logic        [MASS_W-1:0]   b_mass;
        logic signed [CHARGE_W-1:0] a_charge;
        logic signed [CHARGE_W-1:0] b_charge;
    } pisf_in_t;

    typedef struct packed {
        logic        [DSQ_W-1:0]   dist_sq;
        logic signed [FORCE_W-1:0] magnitude;
        logic signed [FORCE_W-1:0] force_x;
        logic signed [FORCE_W-1:0] force_y;
        logic signed [FORCE_W-1:0] force_z;
        logic                      zero_dist;
        logic                      saturated;
    } pisf_out_t;

endpackage

/* rtl/pisf_udiv.sv */
// ----------------------------------------------------------------------------
// pisf_udiv: pipelined restoring divider
// One quotient bit per stage. The starting remainder must be below the
// divisor; the quotient leaves the last stage, each stage advancing on en.
// ----------------------------------------------------------------------------
module pisf_udiv #(
    parameter int DEN_W = pisf_pkg::DSQ_W,
    parameter int Q_W   = pisf_pkg::MAG_W
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [DEN_W-1:0] rem_in,
    input  logic [Q_W-1:0]   num_in,
    input  logic [DEN_W-1:0] den_in,
    output logic [Q_W-1:0]   quo_out
);

    logic [DEN_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   num_reg [Q_W];
    logic [DEN_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];

    for (genvar i = 0; i < Q_W; i++) begin : g_step
        logic [DEN_W-1:0] rem_prev, den_prev, rem_next;
        logic [Q_W-1:0]   num_prev, quo_prev, num_next, quo_next;
        logic [DEN_W:0]   trial, diff;
        logic             fits;

        if (i == 0) begin : g_first
            assign rem_prev = rem_in;
            assign num_prev = num_in;
            assign den_prev = den_in;
            assign quo_prev = '0;
        end else begin : g_rest
            assign rem_prev = rem_reg[i-1];
            assign num_prev = num_reg[i-1];
            assign den_prev = den_reg[i-1];
            assign quo_prev = quo_reg[i-1];
        end

        always_comb begin
            trial    = {rem_prev, num_prev[Q_W-1]};
            diff     = trial - {1'b0, den_prev};
            fits     = trial >= {1'b0, den_prev};
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_next = {num_prev[Q_W-2:0], 1'b0};
            quo_next = {quo_prev[Q_W-2:0], fits};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= rem_next;
                num_reg[i] <= num_next;
                den_reg[i] <= den_prev;
                quo_reg[i] <= quo_next;
            end
        end
    end

    assign quo_out = quo_reg[Q_W-1];

endmodule

/* rtl/pisf_isqrt.sv */
// ----------------------------------------------------------------------------
// pisf_isqrt: pipelined integer square root
// Digit-by-digit floor square root, one root bit per stage; the root
// leaves the last stage, each stage advancing on en.
// ----------------------------------------------------------------------------
module pisf_isqrt #(
    parameter int R_W = pisf_pkg::ROOT_W
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [2*R_W-1:0] n_in,
    output logic [R_W-1:0]   root_out
);

    localparam int REM_W = R_W + 1;
    localparam int CUR_W = R_W + 3;

    logic [REM_W-1:0]   rem_reg  [R_W];
    logic [2*R_W-1:0]   n_reg    [R_W];
    logic [R_W-1:0]     root_reg [R_W];

    for (genvar i = 0; i < R_W; i++) begin : g_step
        logic [REM_W-1:0] rem_prev, rem_next;
        logic [2*R_W-1:0] n_prev, n_next;
        logic [R_W-1:0]   root_prev, root_next;
        logic [CUR_W-1:0] cur, test, diff;
        logic             fits;

        if (i == 0) begin : g_first
            assign rem_prev  = '0;
            assign n_prev    = n_in;
            assign root_prev = '0;
        end else begin : g_rest
            assign rem_prev  = rem_reg[i-1];
            assign n_prev    = n_reg[i-1];
            assign root_prev = root_reg[i-1];
        end

        always_comb begin
            cur       = {rem_prev, n_prev[2*R_W-1 -: 2]};
            test      = {1'b0, root_prev, 2'b01};
            diff      = cur - test;
            fits      = cur >= test;
            rem_next  = fits ? diff[REM_W-1:0] : cur[REM_W-1:0];
            n_next    = {n_prev[2*R_W-3:0], 2'b00};
            root_next = {root_prev[R_W-2:0], fits};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= rem_next;
                n_reg[i]    <= n_next;
                root_reg[i] <= root_next;
            end
        end
    end

    assign root_out = root_reg[R_W-1];

endmodule

/* rtl/pairwise_inverse_square_force_unit.sv */
// ----------------------------------------------------------------------------
// pairwise_inverse_square_force_unit: streaming pairwise force pipeline
// Takes one body pair per word and returns the squared distance, the
// k*p1*p2/r^2 magnitude and the force vector in Q24.24.
//
// Usage:
//   s_ channel: one pisf_in_t word per body pair (valid/ready).
//   m_ channel: one pisf_out_t word per accepted pair, in order.
//   cfg channel: writes grav_constant (index 0) or elec_constant
//   (index 1); cfg_ready is always high. Write only while idle.
// Timing:
//   Throughput is one word per cycle while the output is not stalled,
//   set by the fully pipelined dividers (47 stages for the magnitude)
//   and square root (25 stages) feeding the cosine dividers (25 stages).
//   When m_ready is low with a result waiting, the whole pipeline holds
//   and s_ready drops; nothing is lost or repeated.
// Reset:
//   aresetn (synchronous, active low) empties the pipeline and sets both
//   constants to 1.
// ----------------------------------------------------------------------------
module pairwise_inverse_square_force_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  pisf_pkg::pisf_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output pisf_pkg::pisf_out_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pisf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pisf_pkg::K_W-1:0]        cfg_data
);

    import pisf_pkg::*;

    localparam int SQRT_LAT = ROOT_W;
    localparam int COS_LAT  = COS_W;
    localparam int JOIN_LAT = SQRT_LAT + COS_LAT;
    localparam int MAG_PAD  = JOIN_LAT - MAG_W;
    localparam int LAT      = 3 + JOIN_LAT + 2;

    typedef struct packed {
        logic [DSQ_W-1:0] dsq;
        logic             zero;
        logic             sat;
        logic             neg;
        logic [2:0]       dneg;
    } side_t;

    logic en;
    logic [LAT-1:0] vld_reg;

    logic [K_W-1:0] grav_k_reg, elec_k_reg;

    // config
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_k_reg <= K_W'(1);
            elec_k_reg <= K_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_e'(cfg_index))
                CFG_GRAV_K: grav_k_reg <= cfg_data;
                CFG_ELEC_K: elec_k_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // flow control
    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // stage 1: offsets, pair product
    logic signed [COORD_W-1:0] pos_a [3];
    logic signed [COORD_W-1:0] pos_b [3];
    logic signed [OFS_W-1:0]   ofs   [3];
    logic [OFS_W-1:0]          ad_next [3];
    logic [CHARGE_W-1:0]       qa_abs, qb_abs, mul_a, mul_b;
    logic                      neg_next;

    logic [OFS_W-1:0]  s1_ad_reg [3];
    logic [2:0]        s1_dneg_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic              s1_neg_reg;
    logic [K_W-1:0]    s1_k_reg;

    assign pos_a[0] = s_data.a_pos_x;
    assign pos_a[1] = s_data.a_pos_y;
    assign pos_a[2] = s_data.a_pos_z;
    assign pos_b[0] = s_data.b_pos_x;
    assign pos_b[1] = s_data.b_pos_y;
    assign pos_b[2] = s_data.b_pos_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ofs[i]     = OFS_W'(pos_a[i]) - OFS_W'(pos_b[i]);
            ad_next[i] = ofs[i][OFS_W-1] ? OFS_W'(-ofs[i]) : OFS_W'(ofs[i]);
        end
        qa_abs   = s_data.a_charge[CHARGE_W-1] ? CHARGE_W'(-s_data.a_charge)
                                               : CHARGE_W'(s_data.a_charge);
        qb_abs   = s_data.b_charge[CHARGE_W-1] ? CHARGE_W'(-s_data.b_charge)
                                               : CHARGE_W'(s_data.b_charge);
        mul_a    = (s_data.func == FUNC_ELEC) ? qa_abs : s_data.a_mass;
        mul_b    = (s_data.func == FUNC_ELEC) ? qb_abs : s_data.b_mass;
        neg_next = (s_data.func == FUNC_ELEC) && (s_data.a_charge != 0)
                   && (s_data.b_charge != 0)
                   && (s_data.a_charge[CHARGE_W-1] != s_data.b_charge[CHARGE_W-1]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s1_ad_reg[i]   <= ad_next[i];
                s1_dneg_reg[i] <= ofs[i][OFS_W-1];
            end
            s1_prod_reg <= PROD_W'(mul_a * mul_b);
            s1_neg_reg  <= neg_next;
            s1_k_reg    <= (s_data.func == FUNC_ELEC) ? elec_k_reg : grav_k_reg;
        end
    end

    // stage 2: squares, partial products of the numerator
    logic [SQ_W-1:0]        s2_sq_reg [3];
    logic [HALF_W+K_W-1:0]  s2_nh_reg, s2_nl_reg;
    logic [OFS_W-1:0]       s2_ad_reg [3];
    logic [2:0]             s2_dneg_reg;
    logic                   s2_neg_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s2_sq_reg[i] <= SQ_W'(s1_ad_reg[i] * s1_ad_reg[i]);
                s2_ad_reg[i] <= s1_ad_reg[i];
            end
            s2_nh_reg   <= (HALF_W+K_W)'(s1_prod_reg[PROD_W-1:HALF_W] * s1_k_reg);
            s2_nl_reg   <= (HALF_W+K_W)'(s1_prod_reg[HALF_W-1:0] * s1_k_reg);
            s2_dneg_reg <= s1_dneg_reg;
            s2_neg_reg  <= s1_neg_reg;
        end
    end

    // stage 3: squared distance, full numerator
    logic [DSQ_W-1:0] s3_dsq_reg;
    logic [NUM_W-1:0] s3_num_reg;
    logic [OFS_W-1:0] s3_ad_reg [3];
    logic [2:0]       s3_dneg_reg;
    logic             s3_neg_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_dsq_reg  <= DSQ_W'(s2_sq_reg[0]) + DSQ_W'(s2_sq_reg[1])
                           + DSQ_W'(s2_sq_reg[2]);
            s3_num_reg  <= {s2_nh_reg, HALF_W'(0)} + NUM_W'(s2_nl_reg);
            s3_ad_reg   <= s2_ad_reg;
            s3_dneg_reg <= s2_dneg_reg;
            s3_neg_reg  <= s2_neg_reg;
        end
    end

    // magnitude division, square root, sideband delay
    logic [MAG_W-1:0]  quo;
    logic [ROOT_W-1:0] root;
    logic              sat_s3;
    side_t             side_reg [JOIN_LAT];
    logic [MAG_W-1:0]  mq_reg   [MAG_PAD];
    logic [OFS_W-1:0]  ad_dly_reg [SQRT_LAT][3];

    // quotient overflows 47 bits exactly when num / 2^47 >= dsq
    assign sat_s3 = DSQ_W'(s3_num_reg[NUM_W-1:MAG_W]) >= s3_dsq_reg;

    pisf_udiv #(
        .DEN_W (DSQ_W),
        .Q_W   (MAG_W)
    ) u_mag_div (
        .aclk    (aclk),
        .en      (en),
        .rem_in  (DSQ_W'(s3_num_reg[NUM_W-1:MAG_W])),
        .num_in  (s3_num_reg[MAG_W-1:0]),
        .den_in  (s3_dsq_reg),
        .quo_out (quo)
    );

    pisf_isqrt #(
        .R_W (ROOT_W)
    ) u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .n_in     (s3_dsq_reg),
        .root_out (root)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= '{dsq: s3_dsq_reg, zero: (s3_dsq_reg == '0), sat: sat_s3,
                             neg: s3_neg_reg, dneg: s3_dneg_reg};
            for (int i = 1; i < JOIN_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            mq_reg[0] <= quo;
            for (int i = 1; i < MAG_PAD; i++) begin
                mq_reg[i] <= mq_reg[i-1];
            end
            ad_dly_reg[0] <= s3_ad_reg;
            for (int i = 1; i < SQRT_LAT; i++) begin
                ad_dly_reg[i] <= ad_dly_reg[i-1];
            end
        end
    end

    // direction cosines
    logic [COS_W-1:0] cosv [3];
    logic [OFS_W-1:0] ad_root [3];

    assign ad_root = ad_dly_reg[SQRT_LAT-1];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        pisf_udiv #(
            .DEN_W (ROOT_W),
            .Q_W   (COS_W)
        ) u_cos_div (
            .aclk    (aclk),
            .en      (en),
            .rem_in  (ROOT_W'(ad_root[a][OFS_W-1:1])),
            .num_in  ({ad_root[a][0], COS_FRAC'(0)}),
            .den_in  (root),
            .quo_out (cosv[a])
        );
    end

    // stage B: saturate magnitude, partial force products
    side_t             side_j;
    logic [MAG_W-1:0]  mag_j;
    logic [HALF_W+COS_W-1:0]        b_plo_reg [3];
    logic [MAG_W-HALF_W+COS_W-1:0]  b_phi_reg [3];
    logic [MAG_W-1:0]  b_mag_reg;
    side_t             b_side_reg;

    assign side_j = side_reg[JOIN_LAT-1];
    assign mag_j  = side_j.sat ? MAG_MAX : mq_reg[MAG_PAD-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                b_plo_reg[i] <= (HALF_W+COS_W)'(mag_j[HALF_W-1:0] * cosv[i]);
                b_phi_reg[i] <= (MAG_W-HALF_W+COS_W)'(mag_j[MAG_W-1:HALF_W] * cosv[i]);
            end
            b_mag_reg  <= mag_j;
            b_side_reg <= side_j;
        end
    end

    // stage C: signs and result word
    logic [FORCE_W-1:0] fabs [3];
    logic [FORCE_W-1:0] fval [3];
    logic               neg_eff;
    logic [FORCE_W-1:0] mag_val;
    pisf_out_t          out_next, out_reg;

    always_comb begin
        neg_eff = b_side_reg.neg && (b_mag_reg != '0);
        mag_val = neg_eff ? FORCE_W'(-{1'b0, b_mag_reg}) : FORCE_W'(b_mag_reg);
        for (int i = 0; i < 3; i++) begin
            fabs[i] = FORCE_W'(b_phi_reg[i]) + FORCE_W'(b_plo_reg[i][HALF_W+COS_W-1:HALF_W]);
            fval[i] = ((fabs[i] != '0) && (neg_eff != b_side_reg.dneg[i]))
                      ? FORCE_W'(-fabs[i]) : fabs[i];
        end
        out_next.dist_sq = b_side_reg.dsq;
        if (b_side_reg.zero) begin
            out_next.magnitude = '0;
            out_next.force_x   = '0;
            out_next.force_y   = '0;
            out_next.force_z   = '0;
            out_next.zero_dist = 1'b1;
            out_next.saturated = 1'b0;
        end else begin
            out_next.magnitude = mag_val;
            out_next.force_x   = fval[0];
            out_next.force_y   = fval[1];
            out_next.force_z   = fval[2];
            out_next.zero_dist = 1'b0;
            out_next.saturated = b_side_reg.sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

`ifndef NO_ASSERTIONS
    a_zero_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_dist |-> m_data.magnitude == '0 && !m_data.saturated)
        else $error("coincident pair with nonzero magnitude or saturation");

    a_sat_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            (m_data.magnitude == FORCE_W'(MAG_MAX)
             || m_data.magnitude == FORCE_W'(-{1'b0, MAG_MAX})))
        else $error("saturated magnitude not clamped");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while pipeline stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word after reset");
`endif

endmodule

/* test/pairwise_inverse_square_force_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_inverse_square_force_unit_tb: self-checking bench for the force unit
// Runs a directed table of body pairs, then random pairs under several
// constant settings. Both stream ends idle at random, and the receiver
// stalls once long enough to fill the pipeline. Every result word is
// checked field by field against a typed row or a fixed-point force model.
// ----------------------------------------------------------------------------
module pairwise_inverse_square_force_unit_tb;
    import pisf_pkg::*;

    localparam int PIPE_LAT  = 55;
    localparam int CYCLE_CAP = 400000;
    localparam int N_RANDOM  = 150;

    typedef struct {
        pisf_in_t  din;
        bit        typed;
        pisf_out_t dout;
    } pair_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    pisf_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    pisf_out_t m_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [K_W-1:0]       cfg_data;

    logic [K_W-1:0] grav_k;
    logic [K_W-1:0] elec_k;
    pisf_out_t      force_expected[$];
    pair_row_t      pair_table[$];
    int             n_errors;
    int             n_sent;
    int             n_checked;
    int             n_sat;
    int             n_zero;
    int             cycles = 0;
    bit             hold_req;

    pairwise_inverse_square_force_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [25:0] root_floor(logic [49:0] v);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] b;
        n = 64'(v);
        res = 0;
        b = 64'd1 << 48;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res[25:0];
    endfunction

    function automatic logic [47:0] signed48(bit neg, logic [47:0] m);
        return neg ? (48'd0 - m) : m;
    endfunction

    function automatic pisf_out_t predict_force(pisf_in_t p);
        pisf_out_t     o;
        logic signed [24:0] d[3];
        logic [24:0]   ad[3];
        logic [49:0]   dsq;
        logic [63:0]   prod;
        logic [23:0]   k;
        logic [127:0]  q;
        logic [46:0]   mag;
        logic [25:0]   r;
        logic [63:0]   c;
        logic [127:0]  f;
        logic [23:0]   qa_m;
        logic [23:0]   qb_m;
        bit            neg;
        bit            fneg;
        d[0] = $signed(p.a_pos_x) - $signed(p.b_pos_x);
        d[1] = $signed(p.a_pos_y) - $signed(p.b_pos_y);
        d[2] = $signed(p.a_pos_z) - $signed(p.b_pos_z);
        dsq = 0;
        for (int i = 0; i < 3; i++) begin
            ad[i] = d[i][24] ? 25'(-d[i]) : 25'(d[i]);
            dsq = dsq + 50'(ad[i]) * 50'(ad[i]);
        end
        neg = 0;
        if (p.func == FUNC_ELEC) begin
            qa_m = p.a_charge[23] ? 24'(-p.a_charge) : 24'(p.a_charge);
            qb_m = p.b_charge[23] ? 24'(-p.b_charge) : 24'(p.b_charge);
            prod = 64'(qa_m) * 64'(qb_m);
            neg = (prod != 0) && (p.a_charge[23] != p.b_charge[23]);
            k = elec_k;
        end else begin
            prod = 64'(p.a_mass) * 64'(p.b_mass);
            k = grav_k;
        end
        o = '0;
        o.dist_sq = dsq;
        if (dsq == 0) begin
            o.zero_dist = 1'b1;
            return o;
        end
        q = (128'(prod) * 128'(k)) / 128'(dsq);
        if (q > 128'(MAG_MAX)) begin
            mag = MAG_MAX;
            o.saturated = 1'b1;
        end else begin
            mag = q[46:0];
        end
        if (mag == 0) neg = 0;
        o.magnitude = signed48(neg, 48'(mag));
        r = root_floor(dsq);
        for (int i = 0; i < 3; i++) begin
            c = (64'(ad[i]) << 24) / 64'(r);
            f = (128'(mag) * 128'(c)) >> 24;
            fneg = (f != 0) && (neg != d[i][24]);
            case (i)
                0: o.force_x = signed48(fneg, f[47:0]);
                1: o.force_y = signed48(fneg, f[47:0]);
                default: o.force_z = signed48(fneg, f[47:0]);
            endcase
        end
        return o;
    endfunction

    function automatic logic [23:0] rand_edge24();
        case ($urandom_range(0, 5))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'h7FFFFF;
            3: return 24'h800000;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic pisf_in_t random_pair();
        pisf_in_t p;
        int       mode;
        int       e;
        logic [23:0] off;
        p = pisf_in_t'(($bits(pisf_in_t))'({$urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom}));
        mode = $urandom_range(0, 9);
        if (mode >= 3 && mode <= 7) begin
            // nearby bodies: small offset per axis
            e = $urandom_range(0, 23);
            off = 24'($urandom) & ((24'd1 << e) - 24'd1);
            p.b_pos_x = p.a_pos_x - ($urandom_range(0, 1) ? off : -off);
            off = 24'($urandom) & ((24'd1 << e) - 24'd1);
            p.b_pos_y = p.a_pos_y - ($urandom_range(0, 1) ? off : -off);
            off = 24'($urandom) & ((24'd1 << e) - 24'd1);
            p.b_pos_z = p.a_pos_z - ($urandom_range(0, 1) ? off : -off);
        end else if (mode == 8) begin
            p.b_pos_x = p.a_pos_x;
            p.b_pos_y = p.a_pos_y;
            p.b_pos_z = p.a_pos_z;
        end else if (mode == 9) begin
            p.a_pos_x = rand_edge24();
            p.a_pos_y = rand_edge24();
            p.a_pos_z = rand_edge24();
            p.b_pos_x = rand_edge24();
            p.b_pos_y = rand_edge24();
            p.b_pos_z = rand_edge24();
        end
        if ($urandom_range(0, 3) == 0) begin
            p.a_mass = rand_edge24();
            p.b_mass = rand_edge24();
            p.a_charge = rand_edge24();
            p.b_charge = rand_edge24();
        end
        return p;
    endfunction

    function automatic int rand_gap();
        int s;
        s = $urandom_range(0, 99);
        if (s < 55) return 0;
        if (s < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_pair(pisf_in_t p, bit typed, pisf_out_t exp_word);
        int g;
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        force_expected.push_back(typed ? exp_word : predict_force(p));
        n_sent++;
        g = rand_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic write_reg(cfg_reg_e idx_code, logic [CFG_IDX_W-1:0] idx,
                             bit by_code, logic [K_W-1:0] v);
        logic [CFG_IDX_W-1:0] ix;
        ix = by_code ? idx_code : idx;
        cfg_valid <= 1'b1;
        cfg_index <= ix;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (ix == CFG_GRAV_K) grav_k = v;
        else if (ix == CFG_ELEC_K) elec_k = v;
        @(posedge aclk);
    endtask

    task automatic drain_idle();
        s_valid <= 1'b0;
        while (force_expected.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 5) @(posedge aclk);
    endtask

    task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $error("%s mismatch: expected %0h actual %0h", name, e, a);
            n_errors++;
        end
    endtask

    always @(posedge aclk) begin
        pisf_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (force_expected.size() == 0) begin
                $error("result word with nothing expected");
                n_errors++;
            end else begin
                e = force_expected.pop_front();
                check_field("dist_sq", e.dist_sq, m_data.dist_sq);
                check_field("magnitude", e.magnitude, m_data.magnitude);
                check_field("force_x", e.force_x, m_data.force_x);
                check_field("force_y", e.force_y, m_data.force_y);
                check_field("force_z", e.force_z, m_data.force_z);
                check_field("zero_dist", e.zero_dist, m_data.zero_dist);
                check_field("saturated", e.saturated, m_data.saturated);
                n_checked++;
                if (e.saturated) n_sat++;
                if (e.zero_dist) n_zero++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off on request
    initial begin
        int g;
        bit held;
        held = 0;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req && !held) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            g = rand_gap();
            m_ready <= (g == 0) || ($urandom_range(0, 3) == 0);
            @(posedge aclk);
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 1) ? 1 : $urandom_range(5, 40)) @(posedge aclk);
        end
    end

    function automatic pisf_in_t mk(logic fn,
        logic [23:0] ax, logic [23:0] ay, logic [23:0] az,
        logic [23:0] bx, logic [23:0] by, logic [23:0] bz,
        logic [23:0] ma, logic [23:0] mb, logic [23:0] qa, logic [23:0] qb);
        pisf_in_t p;
        p.func = fn;
        p.a_pos_x = ax; p.a_pos_y = ay; p.a_pos_z = az;
        p.b_pos_x = bx; p.b_pos_y = by; p.b_pos_z = bz;
        p.a_mass = ma; p.b_mass = mb; p.a_charge = qa; p.b_charge = qb;
        return p;
    endfunction

    task automatic add_row(pisf_in_t p, bit typed, pisf_out_t o);
        pair_row_t row;
        row.din = p;
        row.typed = typed;
        row.dout = o;
        pair_table.push_back(row);
    endtask

    initial begin
        pisf_out_t o;
        pisf_out_t none;
        pisf_in_t  p;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        grav_k    = 24'd1;
        elec_k    = 24'd1;
        n_errors = 0; n_sent = 0; n_checked = 0; n_sat = 0; n_zero = 0;
        hold_req = 0;
        none = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // unit offset on x, zero masses
        o = '0; o.dist_sq = 50'd1 << 24;
        add_row(mk(FUNC_GRAV, 24'd4096, 0, 0, 0, 0, 0, 0, 0, 24'h7FFFFF, 24'h800000), 1, o);
        // coincident bodies
        o = '0; o.zero_dist = 1'b1;
        add_row(mk(FUNC_ELEC, 24'h123456, 24'h800000, 24'h7FFFFF,
                   24'h123456, 24'h800000, 24'h7FFFFF,
                   24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h800000), 1, o);
        add_row(mk(FUNC_GRAV, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                   24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                   24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF), 1, o);
        // magnitude overflow at one-lsb separation
        o = '0; o.dist_sq = 50'd1; o.magnitude = 48'(MAG_MAX);
        o.force_x = 48'(MAG_MAX); o.saturated = 1'b1;
        add_row(mk(FUNC_GRAV, 24'd1, 0, 0, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 0), 1, o);
        add_row(mk(FUNC_GRAV, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                   24'h800000, 24'h800000, 24'h800000,
                   24'hFFFFFF, 24'hFFFFFF, 0, 0), 0, none);
        add_row(mk(FUNC_ELEC, 24'h800000, 24'h800000, 24'h800000,
                   24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                   0, 0, 24'h800000, 24'h800000), 0, none);
        add_row(mk(FUNC_ELEC, 0, 24'd1, 0, 0, 0, 0, 0, 0, 24'h7FFFFF, 24'h800000), 0, none);
        add_row(mk(FUNC_ELEC, 0, 0, 24'hFFFFFF, 0, 0, 0, 0, 0, 24'h800000, 24'h800000),
                0, none);
        add_row(mk(FUNC_ELEC, 24'd300, 24'hFFF000, 24'd77, 0, 0, 0,
                   24'hFFFFFF, 24'hFFFFFF, 0, 24'h800000), 0, none);
        add_row(mk(FUNC_ELEC, 24'hFFFFF0, 24'd5, 24'hFFFF00, 24'd3, 24'hFFFFF8, 24'd9,
                   0, 0, 24'hFFFFFF, 24'h000001), 0, none);
        add_row(mk(FUNC_GRAV, 24'h000100, 24'h000200, 24'h000300,
                   24'hFFFF00, 24'hFFFE00, 24'hFFFD00,
                   24'h001000, 24'h002000, 0, 0), 0, none);
        add_row(mk(FUNC_ELEC, 24'h000010, 24'h7FFFFF, 24'h000000,
                   24'h000000, 24'h7FFFFF, 24'h000000,
                   24'h555555, 24'hAAAAAA, 24'h7FFFFF, 24'h7FFFFF), 0, none);
        for (int i = 0; i < 6; i++) add_row(random_pair(), 0, none);

        foreach (pair_table[i])
            send_pair(pair_table[i].din, pair_table[i].typed, pair_table[i].dout);
        drain_idle();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_GRAV_K, 0, 1, 24'hFFFFFF);
                    write_reg(CFG_ELEC_K, 0, 1, 24'hFFFFFF);
                end
                1: begin
                    write_reg(CFG_GRAV_K, 0, 1, 24'd0);
                    write_reg(CFG_ELEC_K, 0, 1, 24'd0);
                    write_reg(CFG_GRAV_K, 2'd2, 0, 24'($urandom));
                    write_reg(CFG_GRAV_K, 2'd3, 0, 24'($urandom));
                end
                2: begin
                    write_reg(CFG_GRAV_K, 0, 1, 24'($urandom));
                    write_reg(CFG_ELEC_K, 0, 1, 24'($urandom));
                end
                default: begin
                    write_reg(CFG_GRAV_K, 0, 1, 24'd1);
                    write_reg(CFG_ELEC_K, 0, 1, 24'($urandom) | 24'h800000);
                end
            endcase
            for (int n = 0; n < N_RANDOM; n++) begin
                if (ph == 0 && n == 20) hold_req = 1;
                p = random_pair();
                send_pair(p, 0, none);
            end
            drain_idle();
        end

        $display("sent %0d pairs over five constant settings, %0d results checked",
                 n_sent, n_checked);
        $display("%0d saturated and %0d coincident pairs seen", n_sat, n_zero);
        if (n_errors == 0 && force_expected.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

/* pairwise_inverse_square_force_unit.f */
rtl/pisf_pkg.sv
rtl/pisf_udiv.sv
rtl/pisf_isqrt.sv
rtl/pairwise_inverse_square_force_unit.sv
test/pairwise_inverse_square_force_unit_tb.sv
